// ===== hdl/iul_pkg.sv =====
package iul_pkg;

  localparam int unsigned MAX_SEGMENTS_DEF = 256;
  localparam int unsigned COORD_WIDTH_DEF  = 32;

  // write control from the sequencer to the point store
  typedef struct packed {
    logic load;   // write an opening/closing pair into set 0
    logic we;     // write one merged point
    logic wset;   // set that takes the merged point
    logic rset;   // set that the read ports look at
  } store_ctl_t;

endpackage

// ===== hdl/iul_store.sv =====
module iul_store #(
  parameter int unsigned MAX_SEGMENTS = iul_pkg::MAX_SEGMENTS_DEF,
  parameter int unsigned KW = iul_pkg::COORD_WIDTH_DEF + 1,
  parameter int unsigned AW = 9
) (
  input  logic                clk,
  input  iul_pkg::store_ctl_t ctl,
  input  logic [AW-1:0]       waddr,
  input  logic [KW-1:0]       wdata,
  input  logic [KW-1:0]       load_open,
  input  logic [KW-1:0]       load_close,
  input  logic [AW-1:0]       raddr_a,
  input  logic [AW-1:0]       raddr_b,
  output logic [KW-1:0]       rdata_a,
  output logic [KW-1:0]       rdata_b
);

  // two sets (ping-pong) of two banks; point index bit 0 picks the bank
  logic [KW-1:0] mem [2][2][MAX_SEGMENTS];
  logic [KW-1:0] rd_a_r [2][2];
  logic [KW-1:0] rd_b_r [2][2];
  logic          bank_a_r, bank_b_r, rset_r;

  for (genvar s = 0; s < 2; s++) begin : g_set
    for (genvar b = 0; b < 2; b++) begin : g_bank
      always_ff @(posedge clk) begin
        if (ctl.load && s == 0) begin
          mem[s][b][waddr[AW-1:1]] <= (b == 0) ? load_open : load_close;
        end else if (ctl.we && ctl.wset == 1'(s) && waddr[0] == 1'(b)) begin
          mem[s][b][waddr[AW-1:1]] <= wdata;
        end
        rd_a_r[s][b] <= mem[s][b][raddr_a[AW-1:1]];
        rd_b_r[s][b] <= mem[s][b][raddr_b[AW-1:1]];
      end
    end
  end

  always_ff @(posedge clk) begin
    bank_a_r <= raddr_a[0];
    bank_b_r <= raddr_b[0];
    rset_r   <= ctl.rset;
  end

  assign rdata_a = rd_a_r[rset_r][bank_a_r];
  assign rdata_b = rd_b_r[rset_r][bank_b_r];

endmodule

// ===== hdl/interval_union_length.sv =====
// the result follows the last request after a bottom-up merge sort of the stored points and a sweep over them;
//   the merge unit spends a read state and a compare state on each point that it writes
// throughput: one request per cycle while loading, then busy for the whole sort and sweep
// reset: rst_n synchronous active low clears the sequencer, point count and overflow flag
// the result strobe out_valid is high for one cycle; the receiver cannot stall
module interval_union_length #(
  parameter int unsigned MAX_SEGMENTS = iul_pkg::MAX_SEGMENTS_DEF,
  parameter int unsigned COORD_WIDTH  = iul_pkg::COORD_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_segment_start,
  input  logic signed [31:0] in_segment_end,
  input  logic               in_segment_last,
  output logic               out_valid,
  output logic [31:0]        out_covered_length,
  output logic               out_overflow
);

  localparam int unsigned DEPTH = 2 * MAX_SEGMENTS;
  localparam int unsigned KW  = COORD_WIDTH + 1;           // biased coord plus open tag
  localparam int unsigned AW  = (MAX_SEGMENTS > 1) ? $clog2(DEPTH) : 2;
  localparam int unsigned CNW = $clog2(DEPTH + 1);          // holds the point count
  localparam int unsigned NW  = CNW + 2;                    // run bounds may pass n
  localparam int unsigned DW  = CNW + 1;                    // signed sweep depth

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PASS = 3'd1;
  localparam logic [2:0] S_RUN  = 3'd2;
  localparam logic [2:0] S_MRD  = 3'd3;
  localparam logic [2:0] S_MCMP = 3'd4;
  localparam logic [2:0] S_SRD  = 3'd5;
  localparam logic [2:0] S_SACC = 3'd6;

  logic [2:0]           state_r, state_nxt;
  logic [CNW-1:0]       count_r, count_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [NW-1:0]        width_r, width_nxt;
  logic [NW-1:0]        lo_r, lo_nxt, mid_r, mid_nxt, hi_r, hi_nxt;
  logic [NW-1:0]        a_r, a_nxt, b_r, b_nxt, k_r, k_nxt;
  logic                 src_r, src_nxt;
  logic [31:0]          total_r, total_nxt;
  logic signed [DW-1:0] depth_r, depth_nxt;
  logic [KW-2:0]        prev_r, prev_nxt;
  logic                 oval_r, oval_nxt;
  logic [31:0]          olen_r, olen_nxt;
  logic                 oovf_r, oovf_nxt;

  logic                 accept;
  logic [COORD_WIDTH-1:0] cs, ce, lo_c, hi_c;
  logic [KW-1:0]        open_key, close_key, rdata_a, rdata_b, wdata;
  logic                 fits, take_a, we;
  logic [NW-1:0]        n_ext, mid_try, hi_try, waddr_full;
  logic [KW-2:0]        gap;
  iul_pkg::store_ctl_t  ctl;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);
  assign n_ext  = NW'(count_r);

  // swap a reversed pair, then flip the sign bit so unsigned order is signed order
  assign cs = in_segment_start[COORD_WIDTH-1:0];
  assign ce = in_segment_end[COORD_WIDTH-1:0];
  always_comb begin
    if ($signed(cs) > $signed(ce)) begin
      lo_c = ce;
      hi_c = cs;
    end else begin
      lo_c = cs;
      hi_c = ce;
    end
  end
  assign open_key  = {~lo_c[COORD_WIDTH-1], lo_c[COORD_WIDTH-2:0], 1'b1};
  assign close_key = {~hi_c[COORD_WIDTH-1], hi_c[COORD_WIDTH-2:0], 1'b0};
  assign fits      = (NW'(count_r) + NW'(2)) <= NW'(DEPTH);

  // shared merge compare: stable, left run wins ties
  assign take_a = (a_r < mid_r) && ((b_r >= hi_r) || (rdata_a <= rdata_b));
  assign wdata  = take_a ? rdata_a : rdata_b;
  assign we     = (state_r == S_MCMP);
  assign gap    = rdata_a[KW-1:1] - prev_r;

  assign mid_try = lo_r + width_r;
  assign hi_try  = lo_r + (width_r << 1);

  // during load the row is the pair index, during merge the output slot
  assign waddr_full = (state_r == S_IDLE) ? NW'(count_r) : k_r;

  always_comb begin
    ctl.load = accept && fits;
    ctl.we   = we;
    ctl.wset = ~src_r;
    ctl.rset = src_r;
  end

  iul_store #(
    .MAX_SEGMENTS(MAX_SEGMENTS),
    .KW(KW),
    .AW(AW)
  ) u_store (
    .clk(clk),
    .ctl(ctl),
    .waddr(waddr_full[AW-1:0]),
    .wdata(wdata),
    .load_open(open_key),
    .load_close(close_key),
    .raddr_a(a_r[AW-1:0]),
    .raddr_b(b_r[AW-1:0]),
    .rdata_a(rdata_a),
    .rdata_b(rdata_b)
  );

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    width_nxt = width_r;
    lo_nxt    = lo_r;
    mid_nxt   = mid_r;
    hi_nxt    = hi_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    k_nxt     = k_r;
    src_nxt   = src_r;
    total_nxt = total_r;
    depth_nxt = depth_r;
    prev_nxt  = prev_r;
    oval_nxt  = 1'b0;
    olen_nxt  = olen_r;
    oovf_nxt  = oovf_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (fits) begin
            count_nxt = count_r + CNW'(2);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_segment_last) begin
            width_nxt = NW'(1);
            src_nxt   = 1'b0;
            state_nxt = S_PASS;
          end
        end
      end
      S_PASS: begin
        lo_nxt = '0;
        if (width_r < n_ext) begin
          state_nxt = S_RUN;
        end else begin
          // sweep setup
          a_nxt     = '0;
          k_nxt     = '0;
          total_nxt = '0;
          depth_nxt = '0;
          state_nxt = (count_r == '0) ? S_SACC : S_SRD;
        end
      end
      S_RUN: begin
        if (lo_r < n_ext) begin
          mid_nxt   = (mid_try > n_ext) ? n_ext : mid_try;
          hi_nxt    = (hi_try > n_ext) ? n_ext : hi_try;
          a_nxt     = lo_r;
          b_nxt     = (mid_try > n_ext) ? n_ext : mid_try;
          k_nxt     = lo_r;
          state_nxt = S_MRD;
        end else begin
          width_nxt = width_r << 1;
          src_nxt   = ~src_r;
          state_nxt = S_PASS;
        end
      end
      S_MRD: begin
        state_nxt = S_MCMP;
      end
      S_MCMP: begin
        if (take_a) begin
          a_nxt = a_r + NW'(1);
        end else begin
          b_nxt = b_r + NW'(1);
        end
        k_nxt = k_r + NW'(1);
        if (k_r + NW'(1) == hi_r) begin
          lo_nxt    = hi_r;
          state_nxt = S_RUN;
        end else begin
          state_nxt = S_MRD;
        end
      end
      S_SRD: begin
        state_nxt = S_SACC;
      end
      S_SACC: begin
        if (k_r != n_ext) begin
          // covered gap since the previous point
          if (k_r != '0 && depth_r > 0) begin
            total_nxt = total_r + 32'(gap);
          end
          depth_nxt = rdata_a[0] ? depth_r + DW'(1) : depth_r - DW'(1);
          prev_nxt  = rdata_a[KW-1:1];
          a_nxt     = a_r + NW'(1);
          k_nxt     = k_r + NW'(1);
        end
        if (k_r == n_ext || k_r + NW'(1) == n_ext) begin
          oval_nxt  = 1'b1;
          olen_nxt  = (k_r == n_ext) ? total_r :
                      ((k_r != '0 && depth_r > 0) ? total_r + 32'(gap) : total_r);
          oovf_nxt  = ovf_r;
          count_nxt = '0;
          ovf_nxt   = 1'b0;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_SRD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ovf_r   <= 1'b0;
      oval_r  <= 1'b0;
      src_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      oval_r  <= oval_nxt;
      src_r   <= src_nxt;
    end
  end

  always_ff @(posedge clk) begin
    width_r <= width_nxt;
    lo_r    <= lo_nxt;
    mid_r   <= mid_nxt;
    hi_r    <= hi_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    k_r     <= k_nxt;
    total_r <= total_nxt;
    depth_r <= depth_nxt;
    prev_r  <= prev_nxt;
    olen_r  <= olen_nxt;
    oovf_r  <= oovf_nxt;
  end

  assign out_valid          = oval_r;
  assign out_covered_length = olen_r;
  assign out_overflow       = oovf_r;

  // a result only appears once the sequencer is back in idle
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");

  // the strobe lasts one cycle
  a_strobe_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held");

  // the point count never passes the store depth
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    NW'(count_r) <= NW'(DEPTH)) else $error("point count past store depth");

  // a result clears the set state
  a_result_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (count_r == '0 && !ovf_r)) else $error("set state kept after result");

endmodule
